### rtl/core/dsoyc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsoyc_pkg;

    localparam int unsigned WYear    = 14;
    localparam int unsigned WMonth   = 4;
    localparam int unsigned WDay     = 5;
    localparam int unsigned WHour    = 5;
    localparam int unsigned WMinute  = 6;
    localparam int unsigned WSecond  = 6;
    localparam int unsigned WSeconds = 25;
    localparam int unsigned WDayNum  = 9;
    localparam int unsigned WTod     = 17;

    localparam logic [WYear-1:0]    YearMax  = 14'd9999;
    localparam logic [WSeconds-1:0] SecsMax  = 25'd31708799;
    localparam logic [WDayNum-1:0]  LastDayCommon = 9'd365;
    localparam logic [WDayNum-1:0]  LastDayLeap   = 9'd366;

    // reciprocal constants for division by constants
    localparam logic [14:0] Div25Mul  = 15'd20972;
    localparam int unsigned Div25Sh   = 19;
    localparam logic [18:0] Div675Mul = 19'd397683;
    localparam int unsigned Div675Sh  = 28;
    localparam logic [12:0] Div225Mul = 13'd4661;
    localparam int unsigned Div225Sh  = 20;
    localparam logic [14:0] Div15Mul  = 15'd17477;
    localparam int unsigned Div15Sh   = 18;

    localparam logic [WMonth-1:0] MonthJan = 4'd1;
    localparam logic [WMonth-1:0] MonthMar = 4'd3;
    localparam logic [WMonth-1:0] MonthDec = 4'd12;

    function automatic logic [WDayNum-1:0] month_offset(input logic [WMonth-1:0] m,
                                                        input logic leap);
        logic [WDayNum-1:0] o;
        case (m)
            4'd1:    o = 9'd0;
            4'd2:    o = 9'd31;
            4'd3:    o = 9'd59;
            4'd4:    o = 9'd90;
            4'd5:    o = 9'd120;
            4'd6:    o = 9'd151;
            4'd7:    o = 9'd181;
            4'd8:    o = 9'd212;
            4'd9:    o = 9'd243;
            4'd10:   o = 9'd273;
            4'd11:   o = 9'd304;
            4'd12:   o = 9'd334;
            default: o = 9'd0;
        endcase
        if (leap && (m >= MonthMar) && (m <= MonthDec)) begin
            o = o + 9'd1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dsoyc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dsoyc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [dsoyc_pkg::WYear-1:0]         year;
    logic [dsoyc_pkg::WMonth-1:0]        month_in;
    logic [dsoyc_pkg::WDay-1:0]          day_in;
    logic [dsoyc_pkg::WHour-1:0]         hour_in;
    logic [dsoyc_pkg::WMinute-1:0]       minute_in;
    logic [dsoyc_pkg::WSecond-1:0]       second_in;
    logic [dsoyc_pkg::WSeconds-1:0]      seconds_in;

    modport source (
        output valid, mode, year, month_in, day_in, hour_in, minute_in, second_in,
               seconds_in,
        input  ready
    );
    modport sink (
        input  valid, mode, year, month_in, day_in, hour_in, minute_in, second_in,
               seconds_in,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/dsoyc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dsoyc_out_if;
    logic                                valid;
    logic                                ready;
    logic [dsoyc_pkg::WSeconds-1:0]      seconds_out;
    logic [dsoyc_pkg::WMonth-1:0]        month_out;
    logic [dsoyc_pkg::WDay-1:0]          day_out;
    logic [dsoyc_pkg::WHour-1:0]         hour_out;
    logic [dsoyc_pkg::WMinute-1:0]       minute_out;
    logic [dsoyc_pkg::WSecond-1:0]       second_out;
    logic                                range_error;

    modport source (
        output valid, seconds_out, month_out, day_out, hour_out, minute_out, second_out,
               range_error,
        input  ready
    );
    modport sink (
        input  valid, seconds_out, month_out, day_out, hour_out, minute_out, second_out,
               range_error,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/date_seconds_of_year_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// date <-> seconds-of-year converter
// i_in carries one conversion request per item: mode 0 turns year, month, day,
// hour, minute and second into a seconds count (jan 1 00:00:00 is 86400), mode 1
// turns a seconds count and a year back into month, day, hour, minute, second.
// o_out carries one result item per request, in order, with range_error set and
// all other fields zero when a checked field is out of range (day_in only for zero).
// three register stages: input register, a middle stage (leap year, day number,
// time of day) and the result register. an accepted item passes from the input
// register through the middle stage into the result register; one item per cycle
// is accepted and delivered when o_out.ready stays high. each logic step between
// stages holds two constant multiplies by a reciprocal.
// reset clears the three stage valid bits; no result is pending afterwards.
// when o_out.ready is low the result holds; the stages behind it keep filling,
// and i_in.ready drops only once all three stages hold an item.
module date_seconds_of_year_converter_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dsoyc_in_if.sink         i_in,
    dsoyc_out_if.source      o_out
);

    // stage valids and advance enables
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic adv1, adv2, adv3;

    assign adv3 = !r_s3_valid || o_out.ready;
    assign adv2 = !r_s2_valid || adv3;
    assign adv1 = !r_s1_valid || adv2;
    assign i_in.ready = adv1;

    // input register
    logic                                r_s1_mode;
    logic [dsoyc_pkg::WYear-1:0]         r_s1_year;
    logic [dsoyc_pkg::WMonth-1:0]        r_s1_month;
    logic [dsoyc_pkg::WDay-1:0]          r_s1_day;
    logic [dsoyc_pkg::WHour-1:0]         r_s1_hour;
    logic [dsoyc_pkg::WMinute-1:0]       r_s1_minute;
    logic [dsoyc_pkg::WSecond-1:0]       r_s1_second;
    logic [dsoyc_pkg::WSeconds-1:0]      r_s1_seconds;

    // middle stage
    logic                                r_s2_mode;
    logic                                r_s2_leap;
    logic                                r_s2_err;
    logic [dsoyc_pkg::WMonth-1:0]        r_s2_month;
    logic [dsoyc_pkg::WDay-1:0]          r_s2_day;
    logic [dsoyc_pkg::WTod-1:0]          r_s2_tsec;
    logic [dsoyc_pkg::WDayNum-1:0]       r_s2_dnum;
    logic [dsoyc_pkg::WTod-1:0]          r_s2_tod;

    // result register
    logic [dsoyc_pkg::WSeconds-1:0]      r_s3_seconds;
    logic [dsoyc_pkg::WMonth-1:0]        r_s3_month;
    logic [dsoyc_pkg::WDay-1:0]          r_s3_day;
    logic [dsoyc_pkg::WHour-1:0]         r_s3_hour;
    logic [dsoyc_pkg::WMinute-1:0]       r_s3_minute;
    logic [dsoyc_pkg::WSecond-1:0]       r_s3_second;
    logic                                r_s3_err;

    // stage 1 logic
    logic [28:0]                         n_yprod;
    logic [9:0]                          n_yq;
    logic [dsoyc_pkg::WYear-1:0]         n_yq25;
    logic                                n_y25zero;
    logic                                n_s2_leap;
    logic                                n_err0;
    logic                                n_err1;
    logic                                n_s2_err;
    logic [dsoyc_pkg::WTod-1:0]          n_s2_tsec;
    logic [36:0]                         n_dprod;
    logic [dsoyc_pkg::WDayNum-1:0]       n_s2_dnum;
    logic [dsoyc_pkg::WSeconds-1:0]      n_dsec;
    logic [dsoyc_pkg::WTod-1:0]          n_s2_tod;
    logic [dsoyc_pkg::WDayNum-1:0]       n_last;

    always_comb begin
        n_yprod   = 29'(r_s1_year) * 29'(dsoyc_pkg::Div25Mul);
        n_yq      = n_yprod[28:dsoyc_pkg::Div25Sh];
        n_yq25    = 14'({n_yq, 4'b0000}) + 14'({n_yq, 3'b000}) + 14'(n_yq);
        n_y25zero = (r_s1_year == n_yq25);
        n_s2_leap = ((r_s1_year[1:0] == 2'b00) && !n_y25zero) ||
                    ((r_s1_year[3:0] == 4'b0000) && n_y25zero);

        n_err0 = (r_s1_year > dsoyc_pkg::YearMax) || (r_s1_month < dsoyc_pkg::MonthJan) ||
                 (r_s1_month > dsoyc_pkg::MonthDec) || (r_s1_day == 5'd0) ||
                 (r_s1_hour > 5'd23) || (r_s1_minute > 6'd59) || (r_s1_second > 6'd59);
        n_s2_tsec = 17'(r_s1_hour) * 17'd3600 + 17'(r_s1_minute) * 17'd60 +
                    17'(r_s1_second);

        n_dprod   = 37'(r_s1_seconds[24:7]) * 37'(dsoyc_pkg::Div675Mul);
        n_s2_dnum = n_dprod[36:dsoyc_pkg::Div675Sh];
        n_dsec    = 25'(n_s2_dnum) * 25'd86400;
        n_s2_tod  = 17'(r_s1_seconds - n_dsec);
        n_last    = n_s2_leap ? dsoyc_pkg::LastDayLeap : dsoyc_pkg::LastDayCommon;
        n_err1    = (r_s1_year > dsoyc_pkg::YearMax) || (r_s1_seconds > dsoyc_pkg::SecsMax) ||
                    (n_s2_dnum > n_last);

        n_s2_err  = r_s1_mode ? n_err1 : n_err0;
    end

    // stage 2 logic
    logic [dsoyc_pkg::WDayNum-1:0]       n_days;
    logic [dsoyc_pkg::WSeconds-1:0]      n_secs;
    logic [dsoyc_pkg::WMonth-1:0]        n_mon;
    logic [dsoyc_pkg::WDayNum-1:0]       n_dom;
    logic [25:0]                         n_hprod;
    logic [dsoyc_pkg::WHour-1:0]         n_hr;
    logic [29:0]                         n_mprod;
    logic [10:0]                         n_tm;
    logic [10:0]                         n_mi;
    logic [dsoyc_pkg::WTod-1:0]          n_se;
    logic [dsoyc_pkg::WSeconds-1:0]      n_s3_seconds;
    logic [dsoyc_pkg::WMonth-1:0]        n_s3_month;
    logic [dsoyc_pkg::WDay-1:0]          n_s3_day;
    logic [dsoyc_pkg::WHour-1:0]         n_s3_hour;
    logic [dsoyc_pkg::WMinute-1:0]       n_s3_minute;
    logic [dsoyc_pkg::WSecond-1:0]       n_s3_second;

    always_comb begin
        n_days = 9'(r_s2_day) + dsoyc_pkg::month_offset(r_s2_month, r_s2_leap);
        n_secs = 25'(n_days) * 25'd86400 + 25'(r_s2_tsec);

        // last month whose offset lies below the day number
        n_mon = 4'd0;
        for (int i = 1; i <= 12; i++) begin
            if (dsoyc_pkg::month_offset(4'(i), r_s2_leap) < r_s2_dnum) begin
                n_mon = 4'(i);
            end
        end
        n_dom = r_s2_dnum - dsoyc_pkg::month_offset(n_mon, r_s2_leap);

        n_hprod = 26'(r_s2_tod[16:4]) * 26'(dsoyc_pkg::Div225Mul);
        n_hr    = n_hprod[24:dsoyc_pkg::Div225Sh];
        n_mprod = 30'(r_s2_tod[16:2]) * 30'(dsoyc_pkg::Div15Mul);
        n_tm    = n_mprod[28:dsoyc_pkg::Div15Sh];
        n_mi    = n_tm - 11'(n_hr) * 11'd60;
        n_se    = r_s2_tod - 17'(n_tm) * 17'd60;

        n_s3_seconds = '0;
        n_s3_month   = '0;
        n_s3_day     = '0;
        n_s3_hour    = '0;
        n_s3_minute  = '0;
        n_s3_second  = '0;
        if (!r_s2_err) begin
            if (!r_s2_mode) begin
                n_s3_seconds = n_secs;
            end else begin
                n_s3_month  = n_mon;
                n_s3_day    = n_dom[4:0];
                n_s3_hour   = n_hr;
                n_s3_minute = n_mi[5:0];
                n_s3_second = n_se[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_valid <= i_in.valid;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_mode    <= i_in.mode;
            r_s1_year    <= i_in.year;
            r_s1_month   <= i_in.month_in;
            r_s1_day     <= i_in.day_in;
            r_s1_hour    <= i_in.hour_in;
            r_s1_minute  <= i_in.minute_in;
            r_s1_second  <= i_in.second_in;
            r_s1_seconds <= i_in.seconds_in;
        end
        if (adv2) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_leap  <= n_s2_leap;
            r_s2_err   <= n_s2_err;
            r_s2_month <= r_s1_month;
            r_s2_day   <= r_s1_day;
            r_s2_tsec  <= n_s2_tsec;
            r_s2_dnum  <= n_s2_dnum;
            r_s2_tod   <= n_s2_tod;
        end
        if (adv3) begin
            r_s3_seconds <= n_s3_seconds;
            r_s3_month   <= n_s3_month;
            r_s3_day     <= n_s3_day;
            r_s3_hour    <= n_s3_hour;
            r_s3_minute  <= n_s3_minute;
            r_s3_second  <= n_s3_second;
            r_s3_err     <= r_s2_err;
        end
    end

    assign o_out.valid       = r_s3_valid;
    assign o_out.seconds_out = r_s3_seconds;
    assign o_out.month_out   = r_s3_month;
    assign o_out.day_out     = r_s3_day;
    assign o_out.hour_out    = r_s3_hour;
    assign o_out.minute_out  = r_s3_minute;
    assign o_out.second_out  = r_s3_second;
    assign o_out.range_error = r_s3_err;

endmodule

`default_nettype wire

### tb/sv/dsoyc_tb_pkg.sv
`timescale 1ns / 1ps

package dsoyc_tb_pkg;

    typedef enum logic {
        ModeDateToSecs = 1'b0,
        ModeSecsToDate = 1'b1
    } conv_mode_e;

    typedef logic [dsoyc_pkg::WYear-1:0]    year_t;
    typedef logic [dsoyc_pkg::WMonth-1:0]   month_t;
    typedef logic [dsoyc_pkg::WDay-1:0]     day_t;
    typedef logic [dsoyc_pkg::WHour-1:0]    hour_t;
    typedef logic [dsoyc_pkg::WMinute-1:0]  minute_t;
    typedef logic [dsoyc_pkg::WSecond-1:0]  second_t;
    typedef logic [dsoyc_pkg::WSeconds-1:0] secs_t;

    typedef struct packed {
        conv_mode_e mode;
        year_t      year;
        month_t     month_in;
        day_t       day_in;
        hour_t      hour_in;
        minute_t    minute_in;
        second_t    second_in;
        secs_t      seconds_in;
    } conv_req_t;

    typedef struct packed {
        secs_t   seconds_out;
        month_t  month_out;
        day_t    day_out;
        hour_t   hour_out;
        minute_t minute_out;
        second_t second_out;
        logic    range_error;
    } conv_res_t;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;

endpackage

### tb/sv/date_seconds_of_year_converter_unit_checker.sv
`timescale 1ns / 1ps

module date_seconds_of_year_converter_unit_checker
    import dsoyc_tb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    dsoyc_in_if   i_req,
    dsoyc_out_if  i_res,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_flagged
);

    localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    conv_res_t expected_q[$];

    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_before_month(int unsigned m, bit leap);
        int unsigned total;
        total = 0;
        if (m >= dsoyc_pkg::MonthJan && m <= dsoyc_pkg::MonthDec) begin
            for (int unsigned i = 1; i < m; i++) begin
                total += MonthDays[i-1];
            end
            if (leap && m >= dsoyc_pkg::MonthMar) begin
                total++;
            end
        end
        return total;
    endfunction

    function automatic conv_res_t convert_request(conv_req_t r);
        conv_res_t    res;
        bit           leap;
        int unsigned  day_num;
        int unsigned  tod;
        int unsigned  last_day;
        int unsigned  mon;
        int unsigned  total;
        res = '0;
        leap = is_leap_year(r.year);
        if (r.mode == ModeDateToSecs) begin
            if (r.year > dsoyc_pkg::YearMax || r.month_in < dsoyc_pkg::MonthJan ||
                r.month_in > dsoyc_pkg::MonthDec || r.day_in == 0 || r.hour_in > 23 ||
                r.minute_in > 59 || r.second_in > 59) begin
                res.range_error = 1'b1;
            end else begin
                total = r.day_in;
                total = (total + days_before_month(r.month_in, leap)) * SecsPerDay;
                total += r.hour_in * SecsPerHour + r.minute_in * SecsPerMin + r.second_in;
                res.seconds_out = secs_t'(total);
            end
        end else begin
            day_num  = r.seconds_in / SecsPerDay;
            tod      = r.seconds_in % SecsPerDay;
            last_day = leap ? dsoyc_pkg::LastDayLeap : dsoyc_pkg::LastDayCommon;
            if (r.year > dsoyc_pkg::YearMax || r.seconds_in > dsoyc_pkg::SecsMax ||
                day_num > last_day) begin
                res.range_error = 1'b1;
            end else begin
                mon = 0;
                for (int unsigned i = 1; i <= 12; i++) begin
                    if (days_before_month(i, leap) < day_num) begin
                        mon = i;
                    end
                end
                res.month_out  = month_t'(mon);
                res.day_out    = day_t'(day_num - days_before_month(mon, leap));
                res.hour_out   = hour_t'(tod / SecsPerHour);
                res.minute_out = minute_t'((tod / SecsPerMin) % 60);
                res.second_out = second_t'(tod % SecsPerMin);
            end
        end
        return res;
    endfunction

    function automatic int field_differs(string name, logic [31:0] exp_val,
                                         logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        conv_req_t req;
        conv_res_t exp_res;
        int        bad;
        if (!i_rst_n) begin
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item arrived with no request pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    bad = field_differs("seconds_out", exp_res.seconds_out, i_res.seconds_out)
                        + field_differs("month_out", exp_res.month_out, i_res.month_out)
                        + field_differs("day_out", exp_res.day_out, i_res.day_out)
                        + field_differs("hour_out", exp_res.hour_out, i_res.hour_out)
                        + field_differs("minute_out", exp_res.minute_out, i_res.minute_out)
                        + field_differs("second_out", exp_res.second_out, i_res.second_out)
                        + field_differs("range_error", exp_res.range_error,
                                        i_res.range_error);
                    if (bad != 0) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    o_checked <= o_checked + 1;
                    if (exp_res.range_error) begin
                        o_flagged <= o_flagged + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                req.mode       = conv_mode_e'(i_req.mode);
                req.year       = i_req.year;
                req.month_in   = i_req.month_in;
                req.day_in     = i_req.day_in;
                req.hour_in    = i_req.hour_in;
                req.minute_in  = i_req.minute_in;
                req.second_in  = i_req.second_in;
                req.seconds_in = i_req.seconds_in;
                expected_q.push_back(convert_request(req));
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

### tb/sv/date_seconds_of_year_converter_unit_test.sv
`timescale 1ns / 1ps

module date_seconds_of_year_converter_unit_test;
    import dsoyc_tb_pkg::*;

    localparam int ResetCycles = 9;
    localparam int RandomItems = 650;
    localparam int QuietItems  = 80;
    localparam int SegmentLen  = 60;
    localparam int DrainCycles = 8;
    localparam int CycleLimit  = 200000;

    logic i_clk;
    logic i_rst_n;

    dsoyc_in_if  req_ch ();
    dsoyc_out_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int flagged;
    int cycle_count = 0;
    int date_items  = 0;
    int secs_items  = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    date_seconds_of_year_converter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    date_seconds_of_year_converter_unit_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_flagged    (flagged)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("date_seconds_of_year_converter_unit_test: done, errors");
            $finish;
        end
    end

    // receiver stalls at random, holding ready low in bursts
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            res_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    function automatic conv_req_t noise_item();
        conv_req_t r;
        r.mode       = ModeDateToSecs;
        r.year       = year_t'($urandom);
        r.month_in   = month_t'($urandom);
        r.day_in     = day_t'($urandom);
        r.hour_in    = hour_t'($urandom);
        r.minute_in  = minute_t'($urandom);
        r.second_in  = second_t'($urandom);
        r.seconds_in = secs_t'($urandom);
        return r;
    endfunction

    function automatic conv_req_t date_item(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi, int unsigned s);
        conv_req_t r;
        r = noise_item();
        r.mode      = ModeDateToSecs;
        r.year      = year_t'(y);
        r.month_in  = month_t'(mo);
        r.day_in    = day_t'(d);
        r.hour_in   = hour_t'(h);
        r.minute_in = minute_t'(mi);
        r.second_in = second_t'(s);
        return r;
    endfunction

    function automatic conv_req_t secs_item(int unsigned y, int unsigned secs);
        conv_req_t r;
        r = noise_item();
        r.mode       = ModeSecsToDate;
        r.year       = year_t'(y);
        r.seconds_in = secs_t'(secs);
        return r;
    endfunction

    // mostly in range, now and then anywhere in the field
    function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned top);
        if ($urandom_range(0, 99) < 8) begin
            return $urandom_range(0, top);
        end
        return $urandom_range(lo, hi);
    endfunction

    function automatic conv_req_t random_item();
        int unsigned p;
        int unsigned y;
        int unsigned secs;
        p = $urandom_range(0, 99);
        if (p < 10) begin
            y = $urandom_range(0, 16383);
        end else if (p < 25) begin
            y = $urandom_range(0, 99) * 100;
        end else begin
            y = $urandom_range(0, 9999);
        end
        if ($urandom_range(0, 1) == 0) begin
            return date_item(y, pick(1, 12, 15), pick(1, 31, 31), pick(0, 23, 31),
                             pick(0, 59, 63), pick(0, 59, 63));
        end
        p = $urandom_range(0, 99);
        if (p < 85) begin
            secs = $urandom_range(0, dsoyc_pkg::SecsMax);
        end else if (p < 95) begin
            secs = $urandom_range(365 * SecsPerDay, dsoyc_pkg::SecsMax);
        end else begin
            secs = $urandom_range(0, 33554431);
        end
        return secs_item(y, secs);
    endfunction

    task automatic send_item(conv_req_t r);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= r.mode;
        req_ch.year       <= r.year;
        req_ch.month_in   <= r.month_in;
        req_ch.day_in     <= r.day_in;
        req_ch.hour_in    <= r.hour_in;
        req_ch.minute_in  <= r.minute_in;
        req_ch.second_in  <= r.second_in;
        req_ch.seconds_in <= r.seconds_in;
        if (r.mode == ModeDateToSecs) begin
            date_items++;
        end else begin
            secs_items++;
        end
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
    endtask

    initial begin
        conv_req_t directed_q[$];
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = ModeDateToSecs;
        req_ch.year       = '0;
        req_ch.month_in   = '0;
        req_ch.day_in     = '0;
        req_ch.hour_in    = '0;
        req_ch.minute_in  = '0;
        req_ch.second_in  = '0;
        req_ch.seconds_in = '0;
        res_ch.ready      = 1'b1;
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_q.push_back(date_item(2023, 1, 1, 0, 0, 0));
        directed_q.push_back(date_item(2024, 12, 31, 23, 59, 59));
        directed_q.push_back(date_item(2000, 3, 1, 0, 0, 0));
        directed_q.push_back(date_item(1900, 3, 1, 0, 0, 0));
        directed_q.push_back(date_item(0, 2, 29, 12, 30, 30));
        directed_q.push_back(date_item(9999, 12, 31, 0, 0, 0));
        directed_q.push_back(date_item(10000, 6, 15, 1, 2, 3));
        directed_q.push_back(date_item(16383, 1, 1, 0, 0, 0));
        directed_q.push_back(date_item(2023, 0, 1, 0, 0, 0));
        directed_q.push_back(date_item(2023, 13, 1, 0, 0, 0));
        directed_q.push_back(date_item(2023, 15, 31, 0, 0, 0));
        directed_q.push_back(date_item(2023, 5, 0, 0, 0, 0));
        directed_q.push_back(date_item(2023, 2, 31, 6, 7, 8));
        directed_q.push_back(date_item(2023, 7, 4, 24, 0, 0));
        directed_q.push_back(date_item(2023, 7, 4, 31, 63, 63));
        directed_q.push_back(date_item(2023, 7, 4, 0, 60, 0));
        directed_q.push_back(date_item(2023, 7, 4, 0, 0, 60));
        // day number zero
        directed_q.push_back(secs_item(2023, 3723));
        directed_q.push_back(secs_item(2023, SecsPerDay));
        directed_q.push_back(secs_item(2024, 60 * SecsPerDay + 3661));
        directed_q.push_back(secs_item(2024, dsoyc_pkg::SecsMax));
        directed_q.push_back(secs_item(2023, dsoyc_pkg::SecsMax));
        directed_q.push_back(secs_item(2023, 366 * SecsPerDay - 1));
        directed_q.push_back(secs_item(2024, dsoyc_pkg::SecsMax + 1));
        directed_q.push_back(secs_item(2024, 33554431));
        directed_q.push_back(secs_item(10000, SecsPerDay));
        directed_q.push_back(secs_item(2100, 366 * SecsPerDay));
        directed_q.push_back(secs_item(2000, 366 * SecsPerDay));

        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed_q[k]) begin
            send_item(directed_q[k]);
        end

        for (int k = 0; k < RandomItems; k++) begin
            quiet = (k >= RandomItems - QuietItems);
            case ((k / SegmentLen) % 3)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 15;
                    stall_pct = 15;
                end
                default: begin
                    gap_pct   = 35;
                    stall_pct = 35;
                end
            endcase
            send_item(random_item());
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("summary: %0d requests sent, %0d date to seconds, %0d seconds to date",
                 date_items + secs_items, date_items, secs_items);
        $display("summary: %0d results compared, %0d of them with the range flag",
                 checked, flagged);
        if (fail_count == 0) begin
            $display("date_seconds_of_year_converter_unit_test: done, clean");
        end else begin
            $display("date_seconds_of_year_converter_unit_test: done, errors");
        end
        $finish;
    end

endmodule
